/* rtl/core/lik_pkg.sv */
// ----------------------------------------------------------------------------
// Leg inverse kinematics package
// Shared widths, pipeline latencies, register indexes and CORDIC constants.
// ----------------------------------------------------------------------------
package lik_pkg;

   // Operand width of the atan2 unit and width of its angle result (2^-20 rad).
   localparam int OP_W = 48;
   localparam int ANG_W = 23;

   // Pipeline depth of the atan2 unit: magnitude, six normalize steps,
   // twenty CORDIC rotations and the quadrant fix-up.
   localparam int ATAN_NORM = 6;
   localparam int ATAN_STEPS = 20;
   localparam int ATAN_LAT = 1 + ATAN_NORM + ATAN_STEPS + 1;

   // Square root input widths.
   localparam int SQ1_W = 32;
   localparam int SQ2_W = 62;

   // Quotient bits of the cosine divider.
   localparam int DIV_STEPS = 30;

   localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = 23'sd1647099;
   localparam logic signed [ANG_W-1:0] PI_Q20 = 23'sd3294199;

   // Configuration register indexes.
   localparam logic [2:0] CSR_COXA_LENGTH = 3'd0;
   localparam logic [2:0] CSR_FEMUR_LENGTH = 3'd1;
   localparam logic [2:0] CSR_TIBIA_LENGTH = 3'd2;
   localparam logic [2:0] CSR_FEMUR_REST = 3'd3;
   localparam logic [2:0] CSR_TIBIA_REST = 3'd4;

   // atan(2^-i) in 2^-20 rad.
   function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
      logic signed [ANG_W-1:0] v;
      unique case (idx)
         0: v = 23'sd823550;
         1: v = 23'sd486170;
         2: v = 23'sd256879;
         3: v = 23'sd130396;
         4: v = 23'sd65451;
         5: v = 23'sd32757;
         6: v = 23'sd16383;
         7: v = 23'sd8192;
         8: v = 23'sd4096;
         9: v = 23'sd2048;
         10: v = 23'sd1024;
         11: v = 23'sd512;
         12: v = 23'sd256;
         13: v = 23'sd128;
         14: v = 23'sd64;
         15: v = 23'sd32;
         16: v = 23'sd16;
         17: v = 23'sd8;
         18: v = 23'sd4;
         19: v = 23'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/core/leg_inverse_kinematics_top.sv */
// ----------------------------------------------------------------------------
// Leg inverse kinematics
// Turns a foot target (x, y, z) into hip yaw, femur and knee angles.
// ----------------------------------------------------------------------------
// The block is a free-running pipeline that takes one request on every clock
// cycle; busy is always low. Each request produces exactly one result, shown
// on the rsp_ ports with rsp_valid high for one cycle, in request order.
// The receiver cannot stall the block, so it must take every result in the
// cycle it appears. The latency is set by the chain of the first square
// root (17 stages), the 30-stage cosine divider, the second square root
// (32 stages) and the 28-stage atan2 unit, with a few multiply and add
// stages in between. The link lengths and rest angles are written through
// the csr_ port, which is always ready; write them only while no request
// is in flight.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_target_x,
   input  logic signed [15:0] req_target_y,
   input  logic signed [15:0] req_target_z,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_hip_yaw,
   output logic signed [15:0] rsp_femur_angle,
   output logic signed [15:0] rsp_knee_angle,
   output logic               rsp_reachable,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import lik_pkg::*;

   // Cycle at which each pipeline register holds its value, counted from the
   // input register.
   localparam int T_SQ = 1;
   localparam int T_HZ = T_SQ + SQ1_W / 2 + 1;
   localparam int T_PR = T_HZ + 1;
   localparam int T_PSQ = T_PR + 1;
   localparam int T_DSQ = T_PSQ + 1;
   localparam int T_NUM = T_DSQ + 1;
   localparam int T_MAG = T_NUM + 1;
   localparam int T_Q = T_MAG + DIV_STEPS;
   localparam int T_C = T_Q + 1;
   localparam int T_CSQ = T_C + 1;
   localparam int T_SARG = T_CSQ + 1;
   localparam int T_S = T_SARG + SQ2_W / 2 + 1;
   localparam int T_MUL = T_S + 1;
   localparam int T_BOP = T_MUL + 1;
   localparam int T_ANG = T_BOP + ATAN_LAT;
   localparam int T_OUT = T_ANG + 1;

   localparam int N_Z = T_PR;
   localparam int N_HIP = T_ANG - ATAN_LAT;
   localparam int N_A = T_ANG - (T_PR + ATAN_LAT);
   localparam int N_REACH = T_ANG - T_NUM;
   localparam int N_C = T_S - T_C;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [61:0] ONE_Q60 = 62'h1000_0000_0000_0000;

   function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
      logic signed [15:0] r;
      if (v > 25'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -25'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Configuration registers and values derived from them.
   // ------------------------------------------------------------------------
   logic [15:0]        coxa_ff, femur_len_ff, tibia_len_ff;
   logic signed [15:0] femur_rest_ff, tibia_rest_ff;
   logic [31:0]        l2sq_ff, l3sq_ff, l23_ff;
   logic [16:0]        hi_ff;
   logic [15:0]        lo_ff;
   logic [33:0]        hisq_ff;
   logic [31:0]        losq_ff;
   logic [32:0]        den;

   always_ff @(posedge clock) begin
      if (reset) begin
         coxa_ff <= 16'd800;
         femur_len_ff <= 16'd1280;
         tibia_len_ff <= 16'd1920;
         femur_rest_ff <= '0;
         tibia_rest_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COXA_LENGTH:  coxa_ff <= csr_data;
            CSR_FEMUR_LENGTH: femur_len_ff <= csr_data;
            CSR_TIBIA_LENGTH: tibia_len_ff <= csr_data;
            CSR_FEMUR_REST:   femur_rest_ff <= csr_data;
            CSR_TIBIA_REST:   tibia_rest_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The reach annulus is |l2 - l3| - 1 .. l2 + l3 + 1, lower end floored at 0.
   always_ff @(posedge clock) begin
      l2sq_ff <= femur_len_ff * femur_len_ff;
      l3sq_ff <= tibia_len_ff * tibia_len_ff;
      l23_ff <= femur_len_ff * tibia_len_ff;
      hi_ff <= {1'b0, femur_len_ff} + {1'b0, tibia_len_ff} + 17'd1;
      if (femur_len_ff > tibia_len_ff) begin
         lo_ff <= femur_len_ff - tibia_len_ff - 16'd1;
      end else if (tibia_len_ff > femur_len_ff) begin
         lo_ff <= tibia_len_ff - femur_len_ff - 16'd1;
      end else begin
         lo_ff <= '0;
      end
      hisq_ff <= hi_ff * hi_ff;
      losq_ff <= lo_ff * lo_ff;
   end

   assign den = {l23_ff, 1'b0};
   assign csr_ready = 1'b1;
   assign busy = 1'b0;

   // ------------------------------------------------------------------------
   // Valid bits travel alongside the data, one per pipeline cycle.
   // ------------------------------------------------------------------------
   logic v_ff [T_OUT+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= T_OUT; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else begin
         v_ff[0] <= start && !busy;
         for (int i = 1; i <= T_OUT; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Horizontal distance and the planar target.
   // ------------------------------------------------------------------------
   logic signed [15:0] x0_ff, y0_ff, z0_ff;
   logic [31:0]        sq_ff;
   logic [16:0]        horiz;
   logic signed [15:0] zd_ff [N_Z];
   logic signed [17:0] pr_ff;
   logic [32:0]        prsq_ff;
   logic [30:0]        zsq_ff;
   logic [33:0]        dsq_ff;
   logic signed [35:0] num_ff;
   logic               reach_ff;
   logic signed [31:0] xsq, ysq;
   logic signed [35:0] prsq;
   logic signed [31:0] zsq;

   always_ff @(posedge clock) begin
      x0_ff <= req_target_x;
      y0_ff <= req_target_y;
      z0_ff <= req_target_z;
   end

   assign xsq = x0_ff * x0_ff;
   assign ysq = y0_ff * y0_ff;
   assign prsq = pr_ff * pr_ff;
   assign zsq = zd_ff[N_Z-1] * zd_ff[N_Z-1];

   always_ff @(posedge clock) begin
      sq_ff <= $unsigned(xsq) + $unsigned(ysq);
      zd_ff[0] <= z0_ff;
      for (int i = 1; i < N_Z; i++) begin
         zd_ff[i] <= zd_ff[i-1];
      end
      pr_ff <= $signed({1'b0, horiz}) - $signed({2'b00, coxa_ff});
      prsq_ff <= prsq[32:0];
      zsq_ff <= zsq[30:0];
      dsq_ff <= {1'b0, prsq_ff} + {3'b000, zsq_ff};
      num_ff <= $signed({2'b00, dsq_ff}) - $signed({4'h0, l2sq_ff})
                - $signed({4'h0, l3sq_ff});
      reach_ff <= (dsq_ff <= hisq_ff) && (dsq_ff >= {2'b00, losq_ff});
   end

   lik_isqrt #(
      .IN_W(SQ1_W)
   ) u_sqrt_horiz (
      .clock(clock),
      .in_value(sq_ff),
      .out_root(horiz)
   );

   // ------------------------------------------------------------------------
   // Knee cosine: (D - l2^2 - l3^2) / (2 l2 l3) in Q30, clamped to +-1.
   // The sign rides along; a magnitude at or above the denominator (or a zero
   // denominator) saturates to one.
   // ------------------------------------------------------------------------
   logic [35:0] mag;
   logic [32:0] mag_ff;
   logic        sat_ff, neg_ff;

   assign mag = num_ff[35] ? 36'(-num_ff) : 36'(num_ff);

   always_ff @(posedge clock) begin
      mag_ff <= mag[32:0];
      sat_ff <= (mag >= {3'b000, den});
      neg_ff <= num_ff[35];
   end

   logic [32:0]           dr_ff [DIV_STEPS-1];
   logic [DIV_STEPS-1:0]  dq_ff [DIV_STEPS];
   logic                  dsat_ff [DIV_STEPS];
   logic                  dneg_ff [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [32:0]          r_p;
      logic [DIV_STEPS-1:0] q_p;
      logic                 sat_p, neg_p;
      logic [33:0]          r2;
      logic                 take;

      if (j == 0) begin : g_first
         assign r_p = mag_ff;
         assign q_p = '0;
         assign sat_p = sat_ff;
         assign neg_p = neg_ff;
      end else begin : g_next
         assign r_p = dr_ff[j-1];
         assign q_p = dq_ff[j-1];
         assign sat_p = dsat_ff[j-1];
         assign neg_p = dneg_ff[j-1];
      end

      assign r2 = {r_p, 1'b0};
      assign take = (r2 >= {1'b0, den});

      always_ff @(posedge clock) begin
         dq_ff[j] <= {q_p[DIV_STEPS-2:0], take};
         dsat_ff[j] <= sat_p;
         dneg_ff[j] <= neg_p;
      end

      if (j < DIV_STEPS - 1) begin : g_rem
         logic [33:0] r_n;
         assign r_n = take ? (r2 - {1'b0, den}) : r2;
         always_ff @(posedge clock) begin
            dr_ff[j] <= r_n[32:0];
         end
      end
   end

   logic [30:0]        cm, cm_ff;
   logic signed [31:0] c_ff;
   logic [61:0]        cmsq_ff, sarg_ff;
   logic signed [31:0] cd_ff [N_C];
   logic [31:0]        sroot;

   assign cm = dsat_ff[DIV_STEPS-1] ? ONE_Q30 : {1'b0, dq_ff[DIV_STEPS-1]};

   always_ff @(posedge clock) begin
      cm_ff <= cm;
      c_ff <= dneg_ff[DIV_STEPS-1] ? -$signed({1'b0, cm}) : $signed({1'b0, cm});
      cmsq_ff <= cm_ff * cm_ff;
      sarg_ff <= ONE_Q60 - cmsq_ff;
      cd_ff[0] <= c_ff;
      for (int i = 1; i < N_C; i++) begin
         cd_ff[i] <= cd_ff[i-1];
      end
   end

   // Knee sine = round(sqrt(2^60 - c^2)).
   lik_isqrt #(
      .IN_W(SQ2_W)
   ) u_sqrt_sine (
      .clock(clock),
      .in_value(sarg_ff),
      .out_root(sroot)
   );

   // ------------------------------------------------------------------------
   // Operands of the knee angle and of the foot-line angle against the femur.
   // ------------------------------------------------------------------------
   logic signed [49:0]     l3s;
   logic signed [48:0]     l3c;
   logic signed [47:0]     l3s_ff, l3c_ff;
   logic [31:0]            s_mul_ff;
   logic signed [31:0]     c_mul_ff;
   logic signed [OP_W-1:0] by_ff, bx_ff, ky_ff, kx_ff;

   assign l3s = $signed({1'b0, tibia_len_ff}) * $signed({1'b0, sroot});
   assign l3c = $signed({1'b0, tibia_len_ff}) * cd_ff[N_C-1];

   always_ff @(posedge clock) begin
      l3s_ff <= l3s[47:0];
      l3c_ff <= l3c[47:0];
      s_mul_ff <= sroot;
      c_mul_ff <= cd_ff[N_C-1];
      by_ff <= l3s_ff;
      bx_ff <= l3c_ff + $signed({2'b00, femur_len_ff, 30'd0});
      ky_ff <= $signed({16'd0, s_mul_ff});
      kx_ff <= {{16{c_mul_ff[31]}}, c_mul_ff};
   end

   // ------------------------------------------------------------------------
   // Angle units.
   // ------------------------------------------------------------------------
   logic signed [ANG_W-1:0] hip_ang, a_ang, b_ang, k_ang;
   logic signed [ANG_W-1:0] hipd_ff [N_HIP];
   logic signed [ANG_W-1:0] ad_ff [N_A];
   logic                    reachd_ff [N_REACH];

   lik_atan2 u_atan_hip (
      .clock(clock),
      .in_y({{32{y0_ff[15]}}, y0_ff}),
      .in_x({{32{x0_ff[15]}}, x0_ff}),
      .out_angle(hip_ang)
   );

   lik_atan2 u_atan_plane (
      .clock(clock),
      .in_y({{32{zd_ff[N_Z-1][15]}}, zd_ff[N_Z-1]}),
      .in_x({{30{pr_ff[17]}}, pr_ff}),
      .out_angle(a_ang)
   );

   lik_atan2 u_atan_offset (
      .clock(clock),
      .in_y(by_ff),
      .in_x(bx_ff),
      .out_angle(b_ang)
   );

   lik_atan2 u_atan_knee (
      .clock(clock),
      .in_y(ky_ff),
      .in_x(kx_ff),
      .out_angle(k_ang)
   );

   always_ff @(posedge clock) begin
      hipd_ff[0] <= hip_ang;
      for (int i = 1; i < N_HIP; i++) begin
         hipd_ff[i] <= hipd_ff[i-1];
      end
      ad_ff[0] <= a_ang;
      for (int i = 1; i < N_A; i++) begin
         ad_ff[i] <= ad_ff[i-1];
      end
      reachd_ff[0] <= reach_ff;
      for (int i = 1; i < N_REACH; i++) begin
         reachd_ff[i] <= reachd_ff[i-1];
      end
   end

   // ------------------------------------------------------------------------
   // Output stage: round 2^-20 rad to 2^-12 rad (add half, floor), subtract
   // the rest angle from the femur and knee angles and saturate to 16 bits.
   // ------------------------------------------------------------------------
   logic signed [23:0] fdiff, fq, kq, hq;
   logic signed [15:0] hip_out_ff, femur_out_ff, knee_out_ff;
   logic               reach_out_ff;

   always_comb begin
      fdiff = 24'(ad_ff[N_A-1]) - 24'(b_ang);
      fq = (fdiff + 24'sd128) >>> 8;
      kq = (24'(k_ang) + 24'sd128) >>> 8;
      hq = (24'(hipd_ff[N_HIP-1]) + 24'sd128) >>> 8;
   end

   always_ff @(posedge clock) begin
      hip_out_ff <= sat16(25'(hq));
      femur_out_ff <= sat16(25'(fq) - 25'(femur_rest_ff));
      knee_out_ff <= sat16(25'(kq) - 25'(tibia_rest_ff));
      reach_out_ff <= reachd_ff[N_REACH-1];
   end

   assign rsp_valid = v_ff[T_OUT];
   assign rsp_hip_yaw = hip_out_ff;
   assign rsp_femur_angle = femur_out_ff;
   assign rsp_knee_angle = knee_out_ff;
   assign rsp_reachable = reach_out_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // Every result traces back to a request taken a fixed latency earlier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, T_OUT + 1))
      else $error("result without a matching request");

   // The divider output, after saturation, stays within +-1.0 in Q30.
   assert property (@(posedge clock) disable iff (reset)
      v_ff[T_C] |-> (c_ff <= 32'sd1073741824) && (c_ff >= -32'sd1073741824))
      else $error("knee cosine out of range");

   // The sine from the second square root never exceeds 1.0 in Q30.
   assert property (@(posedge clock) disable iff (reset)
      v_ff[T_S] |-> (sroot <= 32'd1073741824))
      else $error("knee sine out of range");

endmodule

/* rtl/core/lik_isqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined rounding square root
// One result bit per stage, then a rounding stage: out = round(sqrt(in)).
// ----------------------------------------------------------------------------
module lik_isqrt #(
   parameter int IN_W = 32
) (
   input  logic                clock,
   input  logic [IN_W-1:0]     in_value,
   output logic [IN_W/2:0]     out_root
);
   import lik_pkg::*;

   localparam int H = IN_W / 2;
   localparam int R = H + 2;

   logic [H-1:0]    root_ff [H];
   logic [R-1:0]    rem_ff  [H];
   logic [IN_W-1:0] dat_ff  [H-1];
   logic [H:0]      out_ff;

   for (genvar i = 0; i < H; i++) begin : g_stage
      logic [H-1:0]    root_prev;
      logic [R-1:0]    rem_prev;
      logic [IN_W-1:0] dat_prev;
      logic [R-1:0]    rem_sh;
      logic [R-1:0]    trial;

      if (i == 0) begin : g_first
         assign root_prev = '0;
         assign rem_prev = '0;
         assign dat_prev = in_value;
      end else begin : g_next
         assign root_prev = root_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign dat_prev = dat_ff[i-1];
      end

      always_comb begin
         rem_sh = {rem_prev[R-3:0], dat_prev[IN_W-1 -: 2]};
         trial = {root_prev, 2'b01};
      end

      always_ff @(posedge clock) begin
         if (rem_sh >= trial) begin
            rem_ff[i] <= rem_sh - trial;
            root_ff[i] <= {root_prev[H-2:0], 1'b1};
         end else begin
            rem_ff[i] <= rem_sh;
            root_ff[i] <= {root_prev[H-2:0], 1'b0};
         end
      end

      if (i < H - 1) begin : g_dat
         always_ff @(posedge clock) begin
            dat_ff[i] <= {dat_prev[IN_W-3:0], 2'b00};
         end
      end
   end

   // Round up when the remainder exceeds the truncated root.
   always_ff @(posedge clock) begin
      if (rem_ff[H-1] > {2'b00, root_ff[H-1]}) begin
         out_ff <= {1'b0, root_ff[H-1]} + {{H{1'b0}}, 1'b1};
      end else begin
         out_ff <= {1'b0, root_ff[H-1]};
      end
   end

   assign out_root = out_ff;

endmodule

/* rtl/core/lik_atan2.sv */
// ----------------------------------------------------------------------------
// Pipelined atan2
// Normalizes the operand magnitudes, runs a vectoring CORDIC one rotation per
// stage, then mirrors the first-quadrant angle into the operands' quadrant.
// ----------------------------------------------------------------------------
module lik_atan2 (
   input  logic                                 clock,
   input  logic signed [lik_pkg::OP_W-1:0]      in_y,
   input  logic signed [lik_pkg::OP_W-1:0]      in_x,
   output logic signed [lik_pkg::ANG_W-1:0]     out_angle
);
   import lik_pkg::*;

   localparam int CW = 44;
   localparam int NW = 41;
   localparam int SGN_N = 1 + ATAN_NORM + ATAN_STEPS;

   logic [OP_W-1:0]         ux_ff, uy_ff, m_ff;
   logic [1:0]              sgn_ff [SGN_N];
   logic [OP_W-1:0]         nux_ff [ATAN_NORM];
   logic [OP_W-1:0]         nuy_ff [ATAN_NORM];
   logic [OP_W-1:0]         nm_ff  [ATAN_NORM-1];
   logic signed [CW-1:0]    cx_ff  [ATAN_STEPS-1];
   logic signed [CW-1:0]    cy_ff  [ATAN_STEPS-1];
   logic signed [ANG_W-1:0] zz_ff  [ATAN_STEPS];
   logic signed [ANG_W-1:0] out_ff;
   logic signed [ANG_W-1:0] zc, zm;

   // Magnitudes and the signs that pick the quadrant at the end.
   always_ff @(posedge clock) begin
      ux_ff <= in_x[OP_W-1] ? 48'(-in_x) : in_x;
      uy_ff <= in_y[OP_W-1] ? 48'(-in_y) : in_y;
      if ((in_x[OP_W-1] ? 48'(-in_x) : in_x) > (in_y[OP_W-1] ? 48'(-in_y) : in_y)) begin
         m_ff <= in_x[OP_W-1] ? 48'(-in_x) : in_x;
      end else begin
         m_ff <= in_y[OP_W-1] ? 48'(-in_y) : in_y;
      end
      sgn_ff[0] <= {in_y[OP_W-1], in_x[OP_W-1]};
      for (int i = 1; i < SGN_N; i++) begin
         sgn_ff[i] <= sgn_ff[i-1];
      end
   end

   // Shift the larger magnitude up to the top bit, 32/16/8/4/2/1 at a time.
   for (genvar k = 0; k < ATAN_NORM; k++) begin : g_norm
      localparam int SH = 32 >> k;
      logic [OP_W-1:0] ux_p, uy_p, m_p;
      logic            up;

      if (k == 0) begin : g_first
         assign ux_p = ux_ff;
         assign uy_p = uy_ff;
         assign m_p = m_ff;
      end else begin : g_next
         assign ux_p = nux_ff[k-1];
         assign uy_p = nuy_ff[k-1];
         assign m_p = nm_ff[k-1];
      end

      assign up = (m_p[OP_W-1 -: SH] == '0);

      always_ff @(posedge clock) begin
         nux_ff[k] <= up ? (ux_p << SH) : ux_p;
         nuy_ff[k] <= up ? (uy_p << SH) : uy_p;
      end

      if (k < ATAN_NORM - 1) begin : g_m
         always_ff @(posedge clock) begin
            nm_ff[k] <= up ? (m_p << SH) : m_p;
         end
      end
   end

   // Vectoring CORDIC, one rotation per stage.
   for (genvar i = 0; i < ATAN_STEPS; i++) begin : g_rot
      logic signed [CW-1:0]    cx_p, cy_p, dx, dy, cx_n, cy_n;
      logic signed [ANG_W-1:0] z_p, z_n;

      if (i == 0) begin : g_first
         assign cx_p = $signed({3'b000, nux_ff[ATAN_NORM-1][OP_W-1 -: NW]});
         assign cy_p = $signed({3'b000, nuy_ff[ATAN_NORM-1][OP_W-1 -: NW]});
         assign z_p = '0;
      end else begin : g_next
         assign cx_p = cx_ff[i-1];
         assign cy_p = cy_ff[i-1];
         assign z_p = zz_ff[i-1];
      end

      always_comb begin
         dx = cy_p >>> i;
         dy = cx_p >>> i;
         cx_n = cx_p;
         cy_n = cy_p;
         z_n = z_p;
         if (cy_p > 0) begin
            cx_n = cx_p + dx;
            cy_n = cy_p - dy;
            z_n = z_p + atan_entry(i);
         end else if (cy_p < 0) begin
            cx_n = cx_p - dx;
            cy_n = cy_p + dy;
            z_n = z_p - atan_entry(i);
         end
      end

      always_ff @(posedge clock) begin
         zz_ff[i] <= z_n;
      end

      if (i < ATAN_STEPS - 1) begin : g_xy
         always_ff @(posedge clock) begin
            cx_ff[i] <= cx_n;
            cy_ff[i] <= cy_n;
         end
      end
   end

   // Clamp to [0, pi/2], then mirror for a negative x and negate for a negative y.
   always_comb begin
      zc = zz_ff[ATAN_STEPS-1];
      if (zc < 0) begin
         zc = '0;
      end
      if (zc > HALF_PI_Q20) begin
         zc = HALF_PI_Q20;
      end
      zm = sgn_ff[SGN_N-1][0] ? (PI_Q20 - zc) : zc;
   end

   always_ff @(posedge clock) begin
      out_ff <= sgn_ff[SGN_N-1][1] ? -zm : zm;
   end

   assign out_angle = out_ff;

endmodule

/* tb/leg_inverse_kinematics_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leg inverse kinematics checker
// Watches the request, result and register channels, computes the expected
// joint angles of every taken request and compares them with the results.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [15:0] req_target_x,
   input  logic signed [15:0] req_target_y,
   input  logic signed [15:0] req_target_z,
   input  logic               rsp_valid,
   input  logic signed [15:0] rsp_hip_yaw,
   input  logic signed [15:0] rsp_femur_angle,
   input  logic signed [15:0] rsp_knee_angle,
   input  logic               rsp_reachable,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 fail_count,
   output int                 pending
);
   import lik_pkg::*;

   typedef struct packed {
      logic signed [15:0] hip_yaw;
      logic signed [15:0] femur_angle;
      logic signed [15:0] knee_angle;
      logic               reachable;
   } joint_angles_type;

   localparam longint ONE_Q30 = 64'sd1 << 30;
   localparam longint HALF_PI = 1647099;
   localparam longint FULL_PI = 3294199;
   localparam longint ARCTAN_Q20 [20] = '{823550, 486170, 256879, 130396, 65451,
      32757, 16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

   logic [15:0]        coxa_len, femur_len, tibia_len;
   logic signed [15:0] femur_rest, tibia_rest;
   joint_angles_type   expected_angles[$];

   function automatic longint unsigned root_round(longint unsigned n0);
      longint unsigned n, res, b;
      n = n0;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      if (n0 - res * res > res) res++;
      return res;
   endfunction

   // Vectoring CORDIC on operands normalized to [2^40, 2^41).
   function automatic longint arctan2_q20(longint y, longint x);
      longint unsigned ux, uy, m;
      longint cx, cy, ang, dx, dy;
      ux = (x < 0) ? -x : x;
      uy = (y < 0) ? -y : y;
      m = (ux > uy) ? ux : uy;
      ang = 0;
      if (m == 0) return 0;
      while (m < (64'd1 << 40)) begin
         ux <<= 1; uy <<= 1; m <<= 1;
      end
      while (m >= (64'd1 << 41)) begin
         ux >>= 1; uy >>= 1; m >>= 1;
      end
      cx = ux;
      cy = uy;
      for (int i = 0; i < 20; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy > 0) begin
            cx += dx; cy -= dy; ang += ARCTAN_Q20[i];
         end else if (cy < 0) begin
            cx -= dx; cy += dy; ang -= ARCTAN_Q20[i];
         end
      end
      if (ang < 0) ang = 0;
      if (ang > HALF_PI) ang = HALF_PI;
      if (x < 0) ang = FULL_PI - ang;
      if (y < 0) ang = -ang;
      return ang;
   endfunction

   function automatic longint to_q12(longint v);
      return (v + 128) >>> 8;
   endfunction

   function automatic logic signed [15:0] clip16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic joint_angles_type solve_leg(longint x, longint y, longint z);
      joint_angles_type r;
      longint l2, l3, horiz, pr, dsq, hi, lo, num, den, c, s, q, knee, a, b;
      longint unsigned mag, cm;
      l2 = femur_len;
      l3 = tibia_len;
      horiz = root_round(x * x + y * y);
      pr = horiz - longint'(coxa_len);
      dsq = pr * pr + z * z;
      hi = l2 + l3 + 1;
      lo = (l2 > l3) ? l2 - l3 : l3 - l2;
      lo = (lo > 0) ? lo - 1 : 0;
      r.reachable = (dsq <= hi * hi) && (dsq >= lo * lo);
      num = dsq - l2 * l2 - l3 * l3;
      den = 2 * l2 * l3;
      if (den == 0) c = (num >= 0) ? ONE_Q30 : -ONE_Q30;
      else if (num >= den) c = ONE_Q30;
      else if (num <= -den) c = -ONE_Q30;
      else begin
         mag = (num < 0) ? -num : num;
         q = (mag << 30) / den;
         c = (num < 0) ? -q : q;
      end
      cm = (c < 0) ? -c : c;
      s = root_round((64'd1 << 60) - cm * cm);
      knee = arctan2_q20(s, c);
      a = arctan2_q20(z, pr);
      b = arctan2_q20(l3 * s, l2 * ONE_Q30 + l3 * c);
      r.hip_yaw = clip16(to_q12(arctan2_q20(y, x)));
      r.femur_angle = clip16(to_q12(a - b) - longint'(femur_rest));
      r.knee_angle = clip16(to_q12(knee) - longint'(tibia_rest));
      return r;
   endfunction

   assign pending = expected_angles.size();

   always @(posedge clock) begin
      joint_angles_type e;
      if (reset) begin
         coxa_len <= 16'd800;
         femur_len <= 16'd1280;
         tibia_len <= 16'd1920;
         femur_rest <= '0;
         tibia_rest <= '0;
         expected_angles.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COXA_LENGTH: coxa_len <= csr_data;
               CSR_FEMUR_LENGTH: femur_len <= csr_data;
               CSR_TIBIA_LENGTH: tibia_len <= csr_data;
               CSR_FEMUR_REST: femur_rest <= csr_data;
               CSR_TIBIA_REST: tibia_rest <= csr_data;
               default: ;
            endcase
         end
         if (start && !busy)
            expected_angles.push_back(solve_leg(req_target_x, req_target_y, req_target_z));
         if (rsp_valid) begin
            if (expected_angles.size() == 0) begin
               $display("%t unexpected result: yaw %0d femur %0d knee %0d reach %0b",
                        $realtime, rsp_hip_yaw, rsp_femur_angle, rsp_knee_angle,
                        rsp_reachable);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_angles.pop_front();
               if (e.hip_yaw !== rsp_hip_yaw || e.femur_angle !== rsp_femur_angle ||
                   e.knee_angle !== rsp_knee_angle || e.reachable !== rsp_reachable) begin
                  $display("%t mismatch: expected yaw %0d femur %0d knee %0d reach %0b",
                           $realtime, e.hip_yaw, e.femur_angle, e.knee_angle, e.reachable);
                  $display("%t           actual   yaw %0d femur %0d knee %0d reach %0b",
                           $realtime, rsp_hip_yaw, rsp_femur_angle, rsp_knee_angle,
                           rsp_reachable);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* tb/leg_inverse_kinematics_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leg inverse kinematics testbench
// Drives foot targets under several link and rest-angle settings, with
// directed corner targets and random ones mostly around the leg's reach,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics_top_tb;
   import lik_pkg::*;

   // The drain wait outlasts the time the block takes to answer, with some margin.
   localparam int DRAIN_CYCLES = 140;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ITEMS_PER_PHASE = 120;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [15:0] req_target_x, req_target_y, req_target_z;
   logic               rsp_valid;
   logic signed [15:0] rsp_hip_yaw, rsp_femur_angle, rsp_knee_angle;
   logic               rsp_reachable;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [15:0]        csr_data;
   int                 fail_count;
   int                 pending;
   int                 quiet_cycles;
   logic               allow_gaps;

   leg_inverse_kinematics_top dut (.*);

   leg_inverse_kinematics_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The watchdog ends a run in which nothing is taken for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Inputs are driven with blocking assignments at the falling edge, so
   // start stays high between back-to-back requests without a glitch.
   task automatic send_target(input int x, input int y, input int z);
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      start = 1'b1;
      req_target_x = 16'(x);
      req_target_y = 16'(y);
      req_target_z = 16'(z);
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Registers change only once every result has come back.
   task automatic drain();
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_leg(input int coxa, input int femur, input int tibia,
                          input int f_rest, input int t_rest);
      drain();
      write_reg(CSR_COXA_LENGTH, 16'(coxa));
      write_reg(CSR_FEMUR_LENGTH, 16'(femur));
      write_reg(CSR_TIBIA_LENGTH, 16'(tibia));
      write_reg(CSR_FEMUR_REST, 16'(f_rest));
      write_reg(CSR_TIBIA_REST, 16'(t_rest));
   endtask

   function automatic int rand_span(input int span);
      int v;
      v = int'($urandom_range(0, 2 * span)) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   // Most targets land around the reach annulus of the current leg; the
   // rest cover the full 16-bit range so every input bit toggles.
   task automatic random_targets(input int count, input int reach);
      int span;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            span = reach + reach / 4 + 4;
            send_target(rand_span(span), rand_span(span), rand_span(span));
         end else begin
            send_target(int'($urandom_range(0, 65535)) - 32768,
                        int'($urandom_range(0, 65535)) - 32768,
                        int'($urandom_range(0, 65535)) - 32768);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_target_x = '0;
      req_target_y = '0;
      req_target_z = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      allow_gaps = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed targets on the reset geometry: origin, field extremes,
      // atan2 on a negative x axis, the reach edges and a fully bent knee.
      send_target(0, 0, 0);
      send_target(32767, 0, 0);
      send_target(-32768, 0, 0);
      send_target(0, 32767, 0);
      send_target(0, -32768, 0);
      send_target(-100, 0, 0);
      send_target(32767, 32767, 32767);
      send_target(-32768, -32768, -32768);
      send_target(800 + 3200, 0, 0);
      send_target(800 + 3201, 0, 0);
      send_target(800 + 3202, 0, 0);
      send_target(800 + 640, 0, 0);
      send_target(800 + 639, 0, 0);
      send_target(800 + 638, 0, 0);
      send_target(800, 0, 0);
      send_target(0, 0, -32768);
      send_target(1, -1, 2000);
      send_target(-2000, 2000, -1500);
      random_targets(ITEMS_PER_PHASE, 4000);

      // Equal links, so the inner reach circle shrinks to a point.
      set_leg(0, 1000, 1000, 32767, -32768);
      send_target(0, 0, 0);
      send_target(1, 0, 0);
      send_target(2000, 0, 0);
      send_target(2001, 0, 0);
      random_targets(ITEMS_PER_PHASE, 2000);

      // Shortest links with the largest coxa; an index past the list too.
      set_leg(65535, 1, 1, -32768, 32767);
      write_reg(3'd5, 16'hFFFF);
      write_reg(3'd7, 16'h1234);
      random_targets(ITEMS_PER_PHASE, 32767);

      // Longest links.
      set_leg(0, 65535, 65535, 1234, -4321);
      random_targets(ITEMS_PER_PHASE, 32767);

      // A zero link length takes the degenerate cosine path.
      set_leg(300, 0, 1500, -100, 100);
      send_target(1800, 0, 0);
      send_target(300, 0, 0);
      random_targets(ITEMS_PER_PHASE, 1800);
      set_leg(300, 2500, 0, 0, 0);
      random_targets(ITEMS_PER_PHASE / 2, 2800);

      // Uneven random geometry.
      set_leg($urandom_range(0, 4000), $urandom_range(1, 8000), $urandom_range(1, 8000),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
      random_targets(ITEMS_PER_PHASE, 12000);

      // Back to the reset geometry, with no gaps for the closing stretch.
      set_leg(800, 1280, 1920, 0, 0);
      random_targets(ITEMS_PER_PHASE, 4000);
      allow_gaps = 1'b0;
      random_targets(ITEMS_PER_PHASE, 4000);

      drain();
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* leg_inverse_kinematics_top.f */
rtl/core/lik_pkg.sv
rtl/core/lik_isqrt.sv
rtl/core/lik_atan2.sv
rtl/core/leg_inverse_kinematics_top.sv
tb/leg_inverse_kinematics_checker.sv
tb/leg_inverse_kinematics_top_tb.sv
